// File: rtl/core/ipv4fhg_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fhg_pkg
// Shared types, constants and the static checksum helper for the IPv4
// fragment header generator.
// ----------------------------------------------------------------------------
package ipv4fhg_pkg;

  // Fragment sizing
  localparam int          FRAG_SIZE = 1480;
  localparam logic [15:0] FRAG_LEN  = 16'(FRAG_SIZE);
  localparam logic [16:0] HDR_BYTES = 17'd60;
  localparam logic [16:0] TOT_MAX   = 17'h0_FFFF;
  localparam int          MAX_FRAGS = 64;
  localparam int          CNT_W     = $clog2(MAX_FRAGS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAGS - 1);

  localparam logic [7:0]  VER_IHL   = 8'h4F;

  // Request queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO    = 3'd4;

  localparam logic [31:0] RST_SRC_ADDR = 32'h0A0D_502B;
  localparam logic [31:0] RST_DST_ADDR = 32'hFFFF_FFFF;
  localparam logic [7:0]  RST_TTL      = 8'd64;
  localparam logic [7:0]  RST_TOS      = 8'hFE;
  localparam logic [7:0]  RST_PROTO    = 8'd6;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [7:0]  proto;
  } cfg_t;

  // Queued request
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] len;
  } req_t;

  // One fragment, before the checksum is added
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] flagoff;
    logic [15:0] tot;
    logic [15:0] off;
    logic [15:0] dlen;
    logic        last;
  } frag_t;

  // Folded ones'-complement sum of the header words that only depend on
  // configuration. Never zero, since the version/IHL word is nonzero.
  function automatic logic [15:0] static_sum(cfg_t c);
    logic [18:0] s;
    logic [16:0] f;
    s = 19'({VER_IHL, c.tos}) + 19'({c.ttl, c.proto})
      + 19'(c.src[31:16]) + 19'(c.src[15:0])
      + 19'(c.dst[31:16]) + 19'(c.dst[15:0]);
    f = 17'(s[15:0]) + 17'(s[18:16]);
    return f[15:0] + 16'(f[16]);
  endfunction

endpackage

// File: rtl/core/ipv4fhg_front.sv
// ----------------------------------------------------------------------------
// ipv4fhg_front
// Request intake: stamps each request with the identification counter and
// queues those that carry payload. Zero-length requests only bump the counter.
// ----------------------------------------------------------------------------
module ipv4fhg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                payload_valid,
  output logic                payload_stall,
  input  logic [15:0]         payload_length,
  input  logic                q_full,
  output logic                q_push,
  output ipv4fhg_pkg::req_t   q_data
);
  import ipv4fhg_pkg::*;

  logic [15:0] packet_id;
  logic        accept;

  assign payload_stall = q_full;
  assign accept        = payload_valid && !q_full;
  assign q_push        = accept && (payload_length != 16'd0);
  assign q_data        = '{ident: packet_id, len: payload_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_id <= 16'd0;
    end else if (accept) begin
      packet_id <= packet_id + 16'd1;
    end
  end

endmodule

// File: rtl/core/ipv4fhg_fifo.sv
// ----------------------------------------------------------------------------
// ipv4fhg_fifo
// Short request queue between intake and fragment generation.
// ----------------------------------------------------------------------------
module ipv4fhg_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ipv4fhg_pkg::req_t  push_data,
  output logic               full,
  input  logic               pop,
  output ipv4fhg_pkg::req_t  pop_data,
  output logic               empty
);
  import ipv4fhg_pkg::*;

  req_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/ipv4fhg_back.sv
// ----------------------------------------------------------------------------
// ipv4fhg_back
// Fragment sequencer: walks one queued request a fragment per cycle while the
// output is not stalled, then a checksum stage feeding the output register.
// ----------------------------------------------------------------------------
module ipv4fhg_back (
  input  logic               clk,
  input  logic               rst,
  input  ipv4fhg_pkg::req_t  q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [15:0]        cfg_sum,
  output logic               header_valid,
  input  logic               header_stall,
  output logic [15:0]        identification,
  output logic [15:0]        flags_and_offset,
  output logic [15:0]        total_len,
  output logic [15:0]        header_checksum,
  output logic [15:0]        data_offset,
  output logic [15:0]        data_length,
  output logic               last_fragment
);
  import ipv4fhg_pkg::*;

  // Sequencer state
  logic             busy;
  logic [15:0]      ident;
  logic [15:0]      len;
  logic [15:0]      off;
  logic [CNT_W-1:0] cnt;

  // Stage 1
  logic             s1_valid;
  frag_t            s1;

  logic             s2_adv;
  logic             s1_adv;
  logic             gen_fire;
  logic [15:0]      remain;
  logic             gen_last;
  logic [15:0]      gen_dlen;
  logic [16:0]      gen_tot;
  frag_t            gen;
  logic [17:0]      csum_raw;
  logic [16:0]      csum_f1;
  logic [15:0]      csum_f2;

  assign s2_adv   = !header_valid || !header_stall;
  assign s1_adv   = !s1_valid || s2_adv;
  assign gen_fire = busy && s1_adv;
  assign q_pop    = !busy && !q_empty;

  always_comb begin
    remain   = len - off;
    gen_last = (remain <= FRAG_LEN);
    gen_dlen = gen_last ? remain : FRAG_LEN;
    gen_tot  = 17'(gen_dlen) + HDR_BYTES;
    if (gen_tot > TOT_MAX) gen_tot = TOT_MAX;
    gen.ident   = ident;
    gen.flagoff = {2'b00, !gen_last, off[15:3]};
    gen.tot     = gen_tot[15:0];
    gen.off     = off;
    gen.dlen    = gen_dlen;
    gen.last    = gen_last;
  end

  // Remaining header words added to the configuration part, folded twice
  always_comb begin
    csum_raw = 18'(cfg_sum) + 18'(s1.tot) + 18'(s1.ident) + 18'(s1.flagoff);
    csum_f1  = 17'(csum_raw[15:0]) + 17'(csum_raw[17:16]);
    csum_f2  = csum_f1[15:0] + 16'(csum_f1[16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (gen_fire && (gen_last || cnt == CNT_LAST)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ident <= q_data.ident;
      len   <= q_data.len;
      off   <= 16'd0;
      cnt   <= '0;
    end else if (gen_fire) begin
      off <= off + FRAG_LEN;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      header_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid     <= gen_fire;
      if (s2_adv) header_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) s1 <= gen;
    if (s2_adv && s1_valid) begin
      identification   <= s1.ident;
      flags_and_offset <= s1.flagoff;
      total_len        <= s1.tot;
      header_checksum  <= ~csum_f2;
      data_offset      <= s1.off;
      data_length      <= s1.dlen;
      last_fragment    <= s1.last;
    end
  end

`ifndef ASSERT_OFF
  // Fragment sizes: full size unless last, last is nonempty and fits
  a_dlen_full : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1.last |-> s1.dlen == FRAG_LEN)
    else $error("non-final fragment not full size");

  a_dlen_last : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.last |-> (s1.dlen != 16'd0) && (s1.dlen <= FRAG_LEN))
    else $error("final fragment length out of range");

  // Sequencer steps by one fragment per fire while it stays busy
  a_step : assert property (@(posedge clk) disable iff (rst)
    gen_fire && !gen_last && (cnt != CNT_LAST) |=>
      busy && (off == $past(off) + FRAG_LEN))
    else $error("fragment offset did not advance");

  // A new request is only loaded when the previous one is done
  a_pop_idle : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> busy && (off == 16'd0) && (cnt == '0))
    else $error("request load did not reset sequencer");
`endif

endmodule

// File: rtl/core/ipv4_fragment_header_generator_core.sv
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator_core
// Top level: configuration registers, request intake, queue and sequencer.
// ----------------------------------------------------------------------------
// Each request on the payload channel produces one 60-byte-header description
// per 1480-byte fragment (at most 45, none for a zero length), in rising
// offset order, with the identification taken from a counter that advances
// once per request. The sequencer emits one fragment per cycle while the
// header channel is not stalled, and loads the next request from the
// four-entry queue once the current one is done; the intake keeps accepting
// requests until that queue is full. A request passes the queue, the
// sequencer load, stage 1 and the output register before its first header
// appears. Configuration writes pass the configuration and configuration-sum
// registers, and must only be made while the block is idle.
module ipv4_fragment_header_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        payload_valid,
  output logic        payload_stall,
  input  logic [15:0] payload_length,
  output logic        header_valid,
  input  logic        header_stall,
  output logic [15:0] identification,
  output logic [15:0] flags_and_offset,
  output logic [15:0] total_len,
  output logic [15:0] header_checksum,
  output logic [15:0] data_offset,
  output logic [15:0] data_length,
  output logic        last_fragment
);
  import ipv4fhg_pkg::*;

  cfg_t        cfg;
  logic [15:0] cfg_sum;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  req_t        q_in;
  req_t        q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src   <= RST_SRC_ADDR;
      cfg.dst   <= RST_DST_ADDR;
      cfg.ttl   <= RST_TTL;
      cfg.tos   <= RST_TOS;
      cfg.proto <= RST_PROTO;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SRC_ADDR: cfg.src   <= cfg_data;
        CFG_DST_ADDR: cfg.dst   <= cfg_data;
        CFG_TTL:      cfg.ttl   <= cfg_data[7:0];
        CFG_TOS:      cfg.tos   <= cfg_data[7:0];
        CFG_PROTO:    cfg.proto <= cfg_data[7:0];
        default:      cfg       <= cfg;
      endcase
    end
  end

  // Configuration-only part of the checksum, kept registered
  always_ff @(posedge clk) begin
    cfg_sum <= static_sum(cfg);
  end

  ipv4fhg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .payload_valid  (payload_valid),
    .payload_stall  (payload_stall),
    .payload_length (payload_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  ipv4fhg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ipv4fhg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_data           (q_out),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .cfg_sum          (cfg_sum),
    .header_valid     (header_valid),
    .header_stall     (header_stall),
    .identification   (identification),
    .flags_and_offset (flags_and_offset),
    .total_len        (total_len),
    .header_checksum  (header_checksum),
    .data_offset      (data_offset),
    .data_length      (data_length),
    .last_fragment    (last_fragment)
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_fragment_header_generator_core. Requests go in
// on the payload channel with random gaps. A scoreboard computes the fragment
// headers each request should produce: identification, flags/offset, total
// length, checksum, data offset/length and the last flag. Every header taken
// off the output channel is compared against the oldest pending one. The run
// covers several register settings, including all-zero and all-one values,
// and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4fhg_pkg::*;

  localparam int          CFG_NUM_REGS   = 5;
  localparam logic [15:0] MORE_FRAGS     = 16'h2000;
  localparam logic [31:0] OFFSET_MASK    = 32'h1FFF;
  localparam int          IDLE_PCT       = 21;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          NUM_PHASES     = 5;
  localparam int          RAND_PER_PHASE = 51;
  localparam int          NUM_DIRECTED   = 23;
  localparam logic [15:0] DIRECTED_LENGTHS [NUM_DIRECTED] = '{
    16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'd1479, 16'd1480, 16'd1481,
    16'd2959, 16'd2960, 16'd2961, 16'd4440, 16'd0, 16'd65535, 16'd65534,
    16'd65528, 16'd65120, 16'd65121, 16'h5555, 16'hAAAA, 16'h8000,
    16'h7FFF, 16'd0
  };

  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] flagoff;
    logic [15:0] tot;
    logic [15:0] csum;
    logic [15:0] off;
    logic [15:0] dlen;
    logic        last;
  } hdr_t;

  // Tracks register copies and the identification counter, and holds the
  // fragment headers still owed by the block.
  class frag_header_tracker;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [7:0]  proto;
    logic [15:0] next_ident;
    hdr_t        headers_due[$];
    int          errors;

    function new();
      src        = RST_SRC_ADDR;
      dst        = RST_DST_ADDR;
      ttl        = RST_TTL;
      tos        = RST_TOS;
      proto      = RST_PROTO;
      next_ident = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SRC_ADDR: src = data;
        CFG_DST_ADDR: dst = data;
        CFG_TTL: ttl = data[7:0];
        CFG_TOS: tos = data[7:0];
        CFG_PROTO: proto = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] header_sum(logic [15:0] ident, logic [15:0] flagoff,
                                     logic [15:0] tot);
      logic [31:0] s;
      s = 32'({VER_IHL, tos}) + 32'(tot) + 32'(ident) + 32'(flagoff)
        + 32'({ttl, proto}) + 32'(src[31:16]) + 32'(src[15:0])
        + 32'(dst[31:16]) + 32'(dst[15:0]);
      while (s[31:16] != 0)
        s = 32'(s[15:0]) + 32'(s[31:16]);
      return ~s[15:0];
    endfunction

    function void note_request(logic [15:0] len);
      logic [31:0] off;
      logic [31:0] remain;
      logic [31:0] dlen;
      logic [31:0] tot;
      int          n;
      bit          last;
      hdr_t        h;
      off  = 0;
      n    = 0;
      last = 0;
      while (!last && off < 32'(len) && n < MAX_FRAGS) begin
        remain    = 32'(len) - off;
        last      = remain <= 32'(FRAG_SIZE);
        dlen      = last ? remain : 32'(FRAG_SIZE);
        tot       = dlen + 32'(HDR_BYTES);
        if (tot > 32'(TOT_MAX))
          tot = 32'(TOT_MAX);
        h.ident   = next_ident;
        h.flagoff = (last ? 16'h0 : MORE_FRAGS) | 16'((off >> 3) & OFFSET_MASK);
        h.tot     = tot[15:0];
        h.csum    = header_sum(h.ident, h.flagoff, h.tot);
        h.off     = off[15:0];
        h.dlen    = dlen[15:0];
        h.last    = last;
        headers_due.push_back(h);
        n++;
        off += 32'(FRAG_SIZE);
      end
      next_ident++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_header(hdr_t got);
      hdr_t want;
      if (headers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected header, expected none, actual %h", $time, got);
        return;
      end
      want = headers_due.pop_front();
      compare_field("identification", want.ident, got.ident);
      compare_field("flags_and_offset", want.flagoff, got.flagoff);
      compare_field("total_len", want.tot, got.tot);
      compare_field("header_checksum", want.csum, got.csum);
      compare_field("data_offset", want.off, got.off);
      compare_field("data_length", want.dlen, got.dlen);
      compare_field("last_fragment", 16'(want.last), 16'(got.last));
    endfunction

    function int pending();
      return headers_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        payload_valid;
  logic        payload_stall;
  logic [15:0] payload_length;
  logic        header_valid;
  logic        header_stall;
  logic [15:0] identification;
  logic [15:0] flags_and_offset;
  logic [15:0] total_len;
  logic [15:0] header_checksum;
  logic [15:0] data_offset;
  logic [15:0] data_length;
  logic        last_fragment;

  frag_header_tracker tracker;
  bit sender_idles;
  bit receiver_idles;
  bit hold_off_req;

  ipv4_fragment_header_generator_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .payload_valid    (payload_valid),
    .payload_stall    (payload_stall),
    .payload_length   (payload_length),
    .header_valid     (header_valid),
    .header_stall     (header_stall),
    .identification   (identification),
    .flags_and_offset (flags_and_offset),
    .total_len        (total_len),
    .header_checksum  (header_checksum),
    .data_offset      (data_offset),
    .data_length      (data_length),
    .last_fragment    (last_fragment)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short payloads; a share of exact and near multiples of the
  // fragment size, and some full-range lengths.
  function automatic logic [15:0] pick_length();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(1, 44);
    if (sel < 5)
      return 16'd0;
    else if (sel < 50)
      return 16'($urandom_range(1, 2 * FRAG_SIZE));
    else if (sel < 70)
      return 16'($urandom_range(2 * FRAG_SIZE + 1, 6 * FRAG_SIZE));
    else if (sel < 80)
      return 16'(k * FRAG_SIZE);
    else if (sel < 85)
      return 16'(k * FRAG_SIZE + $urandom_range(0, 2) - 1);
    else
      return 16'($urandom_range(0, 65535));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_request(input logic [15:0] len);
    while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
      payload_valid <= 1'b0;
      @(negedge clk);
    end
    payload_valid  <= 1'b1;
    payload_length <= len;
    do @(posedge clk); while (payload_stall);
    tracker.note_request(len);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_registers(input int ph);
    logic [31:0] v [CFG_NUM_REGS];
    for (int i = 0; i < CFG_NUM_REGS; i++)
      v[i] = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
    write_reg(CFG_SRC_ADDR, v[0]);
    write_reg(CFG_DST_ADDR, v[1]);
    write_reg(CFG_TTL, v[2]);
    write_reg(CFG_TOS, v[3]);
    write_reg(CFG_PROTO, v[4]);
    // unmapped index, must leave every register alone
    write_reg(3'(CFG_NUM_REGS + ph % 3), $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: random stall, plus one long hold-off on request.
  initial begin
    header_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          header_stall <= 1'b1;
          @(negedge clk);
        end
      end
      header_stall <= receiver_idles && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Header checking and watchdog.
  initial begin
    hdr_t got;
    int   quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst && header_valid && !header_stall) begin
        got.ident   = identification;
        got.flagoff = flags_and_offset;
        got.tot     = total_len;
        got.csum    = header_checksum;
        got.off     = data_offset;
        got.dlen    = data_length;
        got.last    = last_fragment;
        tracker.check_header(got);
      end
      if ((payload_valid && !payload_stall) || (header_valid && !header_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("** ipv4_fragment_header_generator_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    payload_valid  = 1'b0;
    payload_length = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_off_req   = 1'b0;
    tracker        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lengths under the reset register values
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer_request(DIRECTED_LENGTHS[i]);
    payload_valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_registers(ph);
      @(negedge clk);
      // phase 3 runs flat out on both sides
      sender_idles   = (ph != 3);
      receiver_idles = (ph != 3);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == NUM_PHASES - 1 && k == 8)
          hold_off_req = 1'b1;
        offer_request(pick_length());
      end
      payload_valid <= 1'b0;
      wait_drained();
    end

    if (tracker.errors == 0)
      $display("** ipv4_fragment_header_generator_core: PASSED **");
    else
      $display("** ipv4_fragment_header_generator_core: FAILED **");
    $finish;
  end

endmodule

// File: ipv4_fragment_header_generator_core.f
rtl/core/ipv4fhg_pkg.sv
rtl/core/ipv4fhg_front.sv
rtl/core/ipv4fhg_fifo.sv
rtl/core/ipv4fhg_back.sv
rtl/core/ipv4_fragment_header_generator_core.sv
tb/testbench.sv
